// ===== rtl/tcw_pkg.sv =====
// shared types, codes and constants of the text console writer
package tcw_pkg;

  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int ACTION_W     = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_W     = 11;
  localparam int CELL_W       = 16;
  localparam int ATTR_W       = 8;
  localparam int IDX_CMP_W    = 13;
  localparam int QDEPTH       = 4;

  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } result_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_BACKSPACE,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_INDEX_W-1:0] idx;
    logic                    idx_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHAR_WR,
    ST_READ_OUT,
    ST_CLEAR,
    ST_SCROLL_COPY,
    ST_SCROLL_DRAIN,
    ST_SCROLL_FILL
  } back_state_t;

endpackage

// ===== rtl/tcw_front.sv =====
// front end: accepts input words and classifies them into commands
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                   item_valid,
  output logic                   item_stall,
  input  tcw_pkg::item_t         item,
  input  tcw_pkg::back_status_t  status,
  input  logic                   q_full,
  output logic                   push,
  output tcw_pkg::cmd_t          push_cmd
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;

  assign item_stall = q_full || status.init_busy;
  assign push       = item_valid && !item_stall;

  always_comb begin
    push_cmd.ch     = item.char_code;
    push_cmd.idx    = item.cell_index;
    push_cmd.idx_ok = (IDX_CMP_W'(item.cell_index) < IDX_CMP_W'(NCELLS));
    case (item.action)
      ACT_PUT: begin
        if (item.char_code == CH_BACKSPACE) begin
          push_cmd.kind = CMD_BACKSPACE;
        end else if (item.char_code == CH_NEWLINE) begin
          push_cmd.kind = CMD_NEWLINE;
        end else begin
          push_cmd.kind = CMD_CHAR;
        end
      end
      ACT_CLEAR: push_cmd.kind = CMD_CLEAR;
      ACT_READ:  push_cmd.kind = CMD_READ;
      default:   push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/tcw_queue.sv =====
// command queue between front and back end
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output tcw_pkg::cmd_t q_cmd,
  input  logic          pop
);
  import tcw_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
// back end: screen memory, cursor and command sequencer
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tcw_pkg::cmd_t                 q_cmd,
  output logic                          pop,
  output tcw_pkg::back_status_t         status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tcw_pkg::result_t              result
);
  import tcw_pkg::*;

  localparam int NCELLS     = ROWS * COLUMNS;
  localparam int AW         = $clog2(NCELLS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int SCROLL_POS = (ROWS - 1) * COLUMNS;
  localparam int COPY_LAST  = SCROLL_POS - 1;

  back_state_t        state, state_next;
  logic [AW-1:0]      cnt, cnt_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [AW-1:0]      pos, pos_next;
  logic [CHAR_W-1:0]  ch, ch_next;
  logic [ATTR_W-1:0]  blank_attr;

  logic [CELL_W-1:0]  mem [NCELLS];
  logic [CELL_W-1:0]  rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic               emit;
  result_t            emit_word;
  logic               out_free;

  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic               last_row;
  logic               last_col;
  logic [AW:0]        nl_pos;
  logic [AW-1:0]      bs_pos;
  logic [CELL_W-1:0]  blank;
  logic               cnt_last;

  assign cfg_ready        = 1'b1;
  assign status.init_busy = (state == ST_INIT);
  assign out_free         = !result_valid || !result_stall;

  assign row_inc  = {1'b0, row} + 1'b1;
  assign col_inc  = {1'b0, col} + 1'b1;
  assign last_row = (row_inc == (ROW_W+1)'(ROWS));
  assign last_col = (col_inc == (COL_W+1)'(COLUMNS));
  assign nl_pos   = {1'b0, pos} - (AW+1)'(col) + (AW+1)'(COLUMNS);
  assign bs_pos   = (pos == '0) ? pos : pos - 1'b1;
  assign blank    = {blank_attr, CH_SPACE};
  assign cnt_last = (cnt == AW'(NCELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      pos        <= '0;
      blank_attr <= RESET_ATTR;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      row   <= row_next;
      col   <= col_next;
      pos   <= pos_next;
      if (cfg_valid && cfg_ready) begin
        blank_attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch <= ch_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_word;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    row_next   = row;
    col_next   = col;
    pos_next   = pos;
    ch_next    = ch;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_word  = '{cursor_position: CURSOR_W'(pos), cell_value: '0, scrolled: 1'b0};
    mem_we     = 1'b0;
    mem_waddr  = cnt;
    mem_wdata  = blank;
    mem_re     = 1'b0;
    mem_raddr  = pos;

    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BLANK;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          case (q_cmd.kind)
            CMD_CHAR: begin
              mem_re     = 1'b1;
              ch_next    = q_cmd.ch;
              state_next = ST_CHAR_WR;
            end
            CMD_BACKSPACE: begin
              if (col != '0) begin
                col_next = col - 1'b1;
              end else if (row != '0) begin
                row_next = row - 1'b1;
                col_next = COL_W'(COLUMNS - 1);
              end
              pos_next  = bs_pos;
              mem_we    = 1'b1;
              mem_waddr = bs_pos;
              emit      = 1'b1;
              emit_word.cursor_position = CURSOR_W'(bs_pos);
            end
            CMD_NEWLINE: begin
              col_next = '0;
              if (last_row) begin
                row_next   = ROW_W'(ROWS - 1);
                pos_next   = AW'(SCROLL_POS);
                cnt_next   = '0;
                state_next = ST_SCROLL_COPY;
              end else begin
                row_next = row_inc[ROW_W-1:0];
                pos_next = nl_pos[AW-1:0];
                emit     = 1'b1;
                emit_word.cursor_position = CURSOR_W'(nl_pos[AW-1:0]);
              end
            end
            CMD_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              pos_next   = '0;
              cnt_next   = '0;
              state_next = ST_CLEAR;
            end
            CMD_READ: begin
              if (q_cmd.idx_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(q_cmd.idx);
                state_next = ST_READ_OUT;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_CHAR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = {rdata[CELL_W-1:CHAR_W], ch};
        if (last_col && last_row) begin
          col_next   = '0;
          row_next   = ROW_W'(ROWS - 1);
          pos_next   = AW'(SCROLL_POS);
          cnt_next   = '0;
          state_next = ST_SCROLL_COPY;
        end else begin
          if (last_col) begin
            col_next = '0;
            row_next = row_inc[ROW_W-1:0];
          end else begin
            col_next = col_inc[COL_W-1:0];
          end
          pos_next   = pos + 1'b1;
          emit       = 1'b1;
          emit_word.cursor_position = CURSOR_W'(pos + 1'b1);
          state_next = ST_IDLE;
        end
      end

      ST_READ_OUT: begin
        emit                 = 1'b1;
        emit_word.cell_value = rdata;
        state_next           = ST_IDLE;
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_SCROLL_COPY: begin
        // read one row ahead, write back what came out last cycle
        mem_re    = 1'b1;
        mem_raddr = cnt + AW'(COLUMNS);
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt - 1'b1;
          mem_wdata = rdata;
        end
        if (cnt == AW'(COPY_LAST)) begin
          state_next = ST_SCROLL_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_SCROLL_DRAIN: begin
        mem_we     = 1'b1;
        mem_wdata  = rdata;
        cnt_next   = cnt + 1'b1;
        state_next = ST_SCROLL_FILL;
      end

      ST_SCROLL_FILL: begin
        mem_we = 1'b1;
        if (cnt_last) begin
          cnt_next           = '0;
          emit               = 1'b1;
          emit_word.scrolled = 1'b1;
          state_next         = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/text_console_writer_core.sv =====
// top level of the text console writer
// Character-cell console over a ROWS x COLUMNS single-port-write screen memory.
// After reset the block blanks every cell of the memory and accepts no word
// meanwhile; configuration writes are taken at any time. Words enter a small
// command queue and are carried out one at a time by the back end: backspace,
// newline and unused actions are handled in the idle state, an ordinary
// character is a read-modify-write of its cell, a cell read reads the memory
// and then returns the value, a clear blanks every cell, and a scroll copies
// each row up one row and blanks the bottom row after the item that caused it.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  tcw_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tcw_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
  import tcw_pkg::*;

  back_status_t status;
  logic         q_full;
  logic         push;
  cmd_t         push_cmd;
  logic         q_valid;
  cmd_t         q_cmd;
  logic         pop;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .status     (status),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level checks of the text console writer and their binding
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_stall,
  input tcw_pkg::result_t           result
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (int'(result.cursor_position) < NCELLS))
    else $error("cursor beyond screen");

  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.scrolled) |->
      ((int'(result.cursor_position) >= (ROWS - 1) * COLUMNS) &&
       (result.cell_value == '0)))
    else $error("scroll word with bad cursor or value");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
